>>> rtl/hsv2rgb_pkg.sv
// Shared types, constants and an arithmetic helper for the HSV to RGB converter.
package hsv2rgb_pkg;

    localparam int FULL        = 255;
    localparam int SECTOR_DEG  = 60;
    localparam int SECTORS     = 6;
    localparam int RECIP_60    = 1093;
    localparam int RECIP_SHIFT = 16;
    localparam int FRAC_NUM    = 17;
    localparam int FRAC_SHIFT  = 2;

    localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
    localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
    localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
    localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
    localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
    localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;

    typedef struct packed {
        logic [2:0] sector;
        logic [7:0] frac;
        logic [7:0] sat;
        logic [7:0] val;
    } t_item;

    // Exact floor(x / 255) for any product of two bytes.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        begin
            sum = {1'b0, x} + 17'(x[15:8]) + 17'd1;
            return sum[15:8];
        end
    endfunction

endpackage

>>> rtl/hsv2rgb_front.sv
// Front stage: accepts a pixel request and splits the hue into sector and fraction.
module hsv2rgb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [9:0]           i_hue,
    input  logic [7:0]           i_sat,
    input  logic [7:0]           i_val,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hsv2rgb_pkg::t_item   o_item
);

    logic                r_valid;
    hsv2rgb_pkg::t_item  r_item;
    hsv2rgb_pkg::t_item  n_item;
    logic [20:0]         recip_prod;
    logic [4:0]          quot;
    logic [9:0]          quot_x60;
    logic [5:0]          rem;
    logic [9:0]          frac_x;
    logic [2:0]          sector;

    always_comb begin
        recip_prod = 21'(i_hue) * 21'(hsv2rgb_pkg::RECIP_60);
        quot       = recip_prod[20:hsv2rgb_pkg::RECIP_SHIFT];
        quot_x60   = 10'(quot) * 10'(hsv2rgb_pkg::SECTOR_DEG);
        rem        = 6'(i_hue - quot_x60);
        frac_x     = 10'(rem) * 10'(hsv2rgb_pkg::FRAC_NUM);
        if (quot >= 5'(2 * hsv2rgb_pkg::SECTORS)) begin
            sector = 3'(quot - 5'(2 * hsv2rgb_pkg::SECTORS));
        end else if (quot >= 5'(hsv2rgb_pkg::SECTORS)) begin
            sector = 3'(quot - 5'(hsv2rgb_pkg::SECTORS));
        end else begin
            sector = 3'(quot);
        end
        n_item.sector = sector;
        n_item.frac   = frac_x[hsv2rgb_pkg::FRAC_SHIFT +: 8];
        n_item.sat    = i_sat;
        n_item.val    = i_val;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

>>> rtl/hsv2rgb_queue.sv
// Small first-in first-out queue between the front and back stages.
module hsv2rgb_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hsv2rgb_pkg::t_item   i_data,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_pop,
    output hsv2rgb_pkg::t_item   o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsv2rgb_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [PTR_W-1:0]    n_wr_ptr;
    logic [PTR_W-1:0]    n_rd_ptr;
    logic                push;
    logic                pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not rise on a lone write");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count did not fall on a lone read");

endmodule

>>> rtl/hsv2rgb_back.sv
// Back pipeline: forms p, q and t and routes them to the colour channels.
module hsv2rgb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  hsv2rgb_pkg::t_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue
);

    logic [3:0]  r_vld;
    logic        en;

    logic [15:0] r1_pprod;
    logic [15:0] r1_fs;
    logic [15:0] r1_fcs;
    logic [7:0]  r1_val;
    logic [2:0]  r1_sector;

    logic [7:0]  r2_p;
    logic [7:0]  r2_a;
    logic [7:0]  r2_b;
    logic [7:0]  r2_val;
    logic [2:0]  r2_sector;

    logic [15:0] r3_qprod;
    logic [15:0] r3_tprod;
    logic [7:0]  r3_p;
    logic [7:0]  r3_val;
    logic [2:0]  r3_sector;

    logic [7:0]  r4_red;
    logic [7:0]  r4_green;
    logic [7:0]  r4_blue;

    logic [7:0]  q;
    logic [7:0]  t;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;

    assign en      = !r_vld[3] || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_vld[3];
    assign o_red   = r4_red;
    assign o_green = r4_green;
    assign o_blue  = r4_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_comb begin
        q = hsv2rgb_pkg::div255(r3_qprod);
        t = hsv2rgb_pkg::div255(r3_tprod);
        unique case (r3_sector)
            hsv2rgb_pkg::SEC_RED_YELLOW: begin
                n_red = r3_val; n_green = t;      n_blue = r3_p;
            end
            hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
                n_red = q;      n_green = r3_val; n_blue = r3_p;
            end
            hsv2rgb_pkg::SEC_GREEN_CYAN: begin
                n_red = r3_p;   n_green = r3_val; n_blue = t;
            end
            hsv2rgb_pkg::SEC_CYAN_BLUE: begin
                n_red = r3_p;   n_green = q;      n_blue = r3_val;
            end
            hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
                n_red = t;      n_green = r3_p;   n_blue = r3_val;
            end
            default: begin
                n_red = r3_val; n_green = r3_p;   n_blue = q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pprod  <= 16'(8'(hsv2rgb_pkg::FULL) - i_item.sat) * 16'(i_item.val);
            r1_fs     <= 16'(i_item.frac) * 16'(i_item.sat);
            r1_fcs    <= 16'(8'(hsv2rgb_pkg::FULL) - i_item.frac) * 16'(i_item.sat);
            r1_val    <= i_item.val;
            r1_sector <= i_item.sector;

            r2_p      <= hsv2rgb_pkg::div255(r1_pprod);
            r2_a      <= 8'(hsv2rgb_pkg::FULL) - hsv2rgb_pkg::div255(r1_fs);
            r2_b      <= 8'(hsv2rgb_pkg::FULL) - hsv2rgb_pkg::div255(r1_fcs);
            r2_val    <= r1_val;
            r2_sector <= r1_sector;

            r3_qprod  <= 16'(r2_a) * 16'(r2_val);
            r3_tprod  <= 16'(r2_b) * 16'(r2_val);
            r3_p      <= r2_p;
            r3_val    <= r2_val;
            r3_sector <= r2_sector;

            r4_red    <= n_red;
            r4_green  <= n_green;
            r4_blue   <= n_blue;
        end
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline advanced while the output was stalled");

endmodule

>>> rtl/hsv_to_rgb_converter_core.sv
// Top level of the HSV to RGB converter: front stage, queue and back pipeline.
//
//  Channel  Direction  Handshake               Payload (lowest bit first)
//  s        in         i_s_tvalid/o_s_tready   hue[9:0], saturation[17:10], value[25:18]
//  m        out        o_m_tvalid/i_m_tready   red[7:0], green[15:8], blue[23:16]
//
// One request is accepted per clock while o_s_tready is high; its result passes
// through the front stage register, the queue and the four back stages, in that
// order, before it is presented on the m channel.
// Reset is synchronous and clears only the valid bits, queue pointers and queue count.
// A stalled output holds the back pipeline; the queue then absorbs the front
// stage until it fills; o_s_tready falls when the front stage also holds a request.
module hsv_to_rgb_converter_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // hue, saturation, brightness_value, zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // red, green, blue
);

    logic                front_valid;
    hsv2rgb_pkg::t_item  front_item;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    hsv2rgb_pkg::t_item  q_item;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;

    hsv2rgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_hue   (i_s_tdata[9:0]),
        .i_sat   (i_s_tdata[17:10]),
        .i_val   (i_s_tdata[25:18]),
        .o_valid (front_valid),
        .i_ready (!q_full),
        .o_item  (front_item)
    );

    hsv2rgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_item)
    );

    hsv2rgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_item  (q_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    assign o_m_tdata = {blue, green, red};

endmodule
